@@ rtl/tam_pkg.sv @@
// Shared constants, register indexes, sequencer states and divider status type
// for the touch averaging and mapping block. No dependencies.
`timescale 1ns / 1ps

package tam_pkg;

    localparam int RAW_W       = 12;   // raw coordinate and calibration width
    localparam int SX_W        = 8;    // screen column field width
    localparam int SY_W        = 9;    // screen row field width
    localparam int MIN_VALID   = 3;    // non-zero samples needed for a touch
    localparam int CFG_IDX_W   = 3;

    localparam int SAMPLES_DEF = 8;
    localparam int WIDTH_DEF   = 240;
    localparam int HEIGHT_DEF  = 320;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SWAP    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_H   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_V   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_H   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_H   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_V   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_V   = 3'd6;

    // register reset values
    localparam logic             RST_SWAP  = 1'b1;
    localparam logic             RST_INV_H = 1'b1;
    localparam logic             RST_INV_V = 1'b0;
    localparam logic [RAW_W-1:0] RST_MIN_H = 12'd25;
    localparam logic [RAW_W-1:0] RST_MAX_H = 12'd222;
    localparam logic [RAW_W-1:0] RST_MIN_V = 12'd31;
    localparam logic [RAW_W-1:0] RST_MAX_V = 12'd281;

    typedef enum logic [9:0] {
        ST_IDLE = 10'b00_0000_0001,
        ST_AVGX = 10'b00_0000_0010,
        ST_AVGY = 10'b00_0000_0100,
        ST_MULX = 10'b00_0000_1000,
        ST_DIVX = 10'b00_0001_0000,
        ST_FIXX = 10'b00_0010_0000,
        ST_MULY = 10'b00_0100_0000,
        ST_DIVY = 10'b00_1000_0000,
        ST_FIXY = 10'b01_0000_0000,
        ST_OUT  = 10'b10_0000_0000
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

@@ rtl/touch_average_and_map_unit.sv @@
// Top level of the touch averaging and mapping block: accumulator, sequencer,
// multiplier step, sign and clamp logic, output register. Uses tam_pkg, tam_div.
`timescale 1ns / 1ps

// Usage
//   s_valid/s_ready carries raw samples (s_sample_x, s_sample_y); a sample with
//   both coordinates zero is counted but not accumulated. After every SAMPLES
//   samples one request leaves on m_valid/m_ready with the touch flag, the two
//   averages and the mapped screen position (all zero when fewer than three
//   samples of the group were non-zero).
//   Calibration is written through cfg_we/cfg_index/cfg_data; the user must
//   write it only while idle, as no check in the block enforces this.
//   Flow: s_ready stays high after a sample that does not close a group. The
//   last sample of a group starts the sequencer, which runs the one shared
//   bit-serial divider four times (two averages, two mappings), plus a multiply
//   and a clamp step per axis and the output step; s_ready is low until then,
//   and s_ready and m_valid rise together when the output step hands the
//   result over. A group without a touch skips the divider runs and goes
//   straight to the output step; a flat raw range skips the division of that
//   axis.
//   The result sits in an output register; further samples are taken while it
//   waits. If the next group finishes before it is taken, the sequencer holds
//   until the receiver takes it.
//   Reset (aresetn, synchronous, active low) clears the group accumulators, the
//   output valid and loads the default calibration; no clearing pass is needed.
module touch_average_and_map_unit #(
    parameter int SAMPLES       = tam_pkg::SAMPLES_DEF,
    parameter int SCREEN_WIDTH  = tam_pkg::WIDTH_DEF,
    parameter int SCREEN_HEIGHT = tam_pkg::HEIGHT_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [tam_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tam_pkg::RAW_W-1:0]      cfg_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [tam_pkg::RAW_W-1:0]      s_sample_x,
    input  logic [tam_pkg::RAW_W-1:0]      s_sample_y,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_touch_valid,
    output logic [tam_pkg::RAW_W-1:0]      m_average_x,
    output logic [tam_pkg::RAW_W-1:0]      m_average_y,
    output logic [tam_pkg::SX_W-1:0]       m_screen_x,
    output logic [tam_pkg::SY_W-1:0]       m_screen_y
);
    import tam_pkg::*;

    localparam int MAX_SIZE = (SCREEN_WIDTH > SCREEN_HEIGHT) ? SCREEN_WIDTH : SCREEN_HEIGHT;
    localparam int SCALE_W  = (MAX_SIZE > 2) ? $clog2(MAX_SIZE) : 1;
    localparam int CNT_W    = $clog2(SAMPLES + 1);
    localparam int SUM_W    = $clog2(SAMPLES * (2 ** RAW_W));
    localparam int PROD_W   = RAW_W + SCALE_W;
    localparam int DIV_W    = (SUM_W > PROD_W) ? SUM_W : PROD_W;
    localparam int DVS_W    = RAW_W;
    localparam int QS_W     = DIV_W + 1;
    localparam int M_W      = QS_W + 1;

    localparam logic [SCALE_W-1:0] WM1 = SCALE_W'(SCREEN_WIDTH - 1);
    localparam logic [SCALE_W-1:0] HM1 = SCALE_W'(SCREEN_HEIGHT - 1);
    localparam logic [CNT_W-1:0]   LAST_CNT = CNT_W'(SAMPLES - 1);
    localparam logic [CNT_W-1:0]   MINV_CNT = CNT_W'(MIN_VALID);

    state_t state_reg, state_next;

    logic             swap_reg, swap_next;
    logic             inv_h_reg, inv_h_next;
    logic             inv_v_reg, inv_v_next;
    logic [RAW_W-1:0] min_h_reg, min_h_next;
    logic [RAW_W-1:0] max_h_reg, max_h_next;
    logic [RAW_W-1:0] min_v_reg, min_v_next;
    logic [RAW_W-1:0] max_v_reg, max_v_next;

    logic [SUM_W-1:0] sum_x_reg, sum_x_next;
    logic [SUM_W-1:0] sum_y_reg, sum_y_next;
    logic [CNT_W-1:0] vcnt_reg, vcnt_next;
    logic [CNT_W-1:0] scnt_reg, scnt_next;
    logic             touch_reg, touch_next;
    logic             start_reg, start_next;
    logic             m_valid_reg, m_valid_next;

    logic [RAW_W-1:0]     avg_x_reg, avg_x_next;
    logic [RAW_W-1:0]     avg_y_reg, avg_y_next;
    logic [DIV_W-1:0]     dvd_reg, dvd_next;
    logic [DVS_W-1:0]     dvs_reg, dvs_next;
    logic                 neg_reg, neg_next;
    logic signed [QS_W-1:0] q_reg, q_next;
    logic [SX_W-1:0]      scr_x_reg, scr_x_next;
    logic [SY_W-1:0]      scr_y_reg, scr_y_next;
    logic                 m_touch_reg, m_touch_next;
    logic [RAW_W-1:0]     m_ax_reg, m_ax_next;
    logic [RAW_W-1:0]     m_ay_reg, m_ay_next;
    logic [SX_W-1:0]      m_sx_reg, m_sx_next;
    logic [SY_W-1:0]      m_sy_reg, m_sy_next;

    div_stat_t        div_stat;
    logic [DIV_W-1:0] div_quot;

    logic                 accept;
    logic                 nonzero;
    logic                 axis_x;
    logic [RAW_W-1:0]     sel_raw, sel_lo, sel_hi;
    logic [SCALE_W-1:0]   size_m1;
    logic                 mirror;
    logic [RAW_W:0]       diff, span;
    logic [RAW_W-1:0]     diff_mag, span_mag;
    logic [PROD_W-1:0]    prod;
    logic signed [M_W-1:0] m_raw;
    logic signed [M_W-1:0] m_clamp;
    logic [QS_W-1:0]      quot_ext;

    tam_div #(
        .DIV_W (DIV_W),
        .DVS_W (DVS_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (start_reg),
        .dividend (dvd_reg),
        .divisor  (dvs_reg),
        .stat     (div_stat),
        .quotient (div_quot)
    );

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign nonzero = (s_sample_x != '0) || (s_sample_y != '0);

    // shared axis selection for the multiply and clamp steps
    always_comb begin
        axis_x   = (state_reg == ST_MULX) || (state_reg == ST_FIXX);
        sel_raw  = (axis_x ^ swap_reg) ? avg_x_reg : avg_y_reg;
        sel_lo   = axis_x ? min_h_reg : min_v_reg;
        sel_hi   = axis_x ? max_h_reg : max_v_reg;
        size_m1  = axis_x ? WM1 : HM1;
        mirror   = axis_x ? inv_h_reg : inv_v_reg;
        diff     = {1'b0, sel_raw} - {1'b0, sel_lo};
        span     = {1'b0, sel_hi} - {1'b0, sel_lo};
        diff_mag = diff[RAW_W] ? RAW_W'(-diff) : diff[RAW_W-1:0];
        span_mag = span[RAW_W] ? RAW_W'(-span) : span[RAW_W-1:0];
        prod     = PROD_W'(diff_mag) * PROD_W'(size_m1);
        quot_ext = {1'b0, div_quot};
        m_raw    = mirror ? (M_W'(size_m1) - M_W'(q_reg)) : M_W'(q_reg);
        if (m_raw < 0) begin
            m_clamp = '0;
        end else if (m_raw > $signed(M_W'(size_m1))) begin
            m_clamp = M_W'(size_m1);
        end else begin
            m_clamp = m_raw;
        end
    end

    always_comb begin
        state_next   = state_reg;
        swap_next    = swap_reg;
        inv_h_next   = inv_h_reg;
        inv_v_next   = inv_v_reg;
        min_h_next   = min_h_reg;
        max_h_next   = max_h_reg;
        min_v_next   = min_v_reg;
        max_v_next   = max_v_reg;
        sum_x_next   = sum_x_reg;
        sum_y_next   = sum_y_reg;
        vcnt_next    = vcnt_reg;
        scnt_next    = scnt_reg;
        touch_next   = touch_reg;
        start_next   = 1'b0;
        m_valid_next = m_valid_reg && !m_ready;
        avg_x_next   = avg_x_reg;
        avg_y_next   = avg_y_reg;
        dvd_next     = dvd_reg;
        dvs_next     = dvs_reg;
        neg_next     = neg_reg;
        q_next       = q_reg;
        scr_x_next   = scr_x_reg;
        scr_y_next   = scr_y_reg;
        m_touch_next = m_touch_reg;
        m_ax_next    = m_ax_reg;
        m_ay_next    = m_ay_reg;
        m_sx_next    = m_sx_reg;
        m_sy_next    = m_sy_reg;

        if (cfg_we) begin
            case (cfg_index)
                CFG_SWAP:  swap_next  = cfg_data[0];
                CFG_INV_H: inv_h_next = cfg_data[0];
                CFG_INV_V: inv_v_next = cfg_data[0];
                CFG_MIN_H: min_h_next = cfg_data;
                CFG_MAX_H: max_h_next = cfg_data;
                CFG_MIN_V: min_v_next = cfg_data;
                CFG_MAX_V: max_v_next = cfg_data;
                default:   ;
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (nonzero) begin
                        sum_x_next = sum_x_reg + SUM_W'(s_sample_x);
                        sum_y_next = sum_y_reg + SUM_W'(s_sample_y);
                        vcnt_next  = vcnt_reg + CNT_W'(1);
                    end
                    scnt_next = scnt_reg + CNT_W'(1);
                    if (scnt_reg == LAST_CNT) begin
                        touch_next = (vcnt_next >= MINV_CNT);
                        if (vcnt_next >= MINV_CNT) begin
                            dvd_next   = DIV_W'(sum_x_next);
                            dvs_next   = DVS_W'(vcnt_next);
                            start_next = 1'b1;
                            state_next = ST_AVGX;
                        end else begin
                            state_next = ST_OUT;
                        end
                    end
                end
            end
            ST_AVGX: begin
                if (div_stat.done) begin
                    avg_x_next = div_quot[RAW_W-1:0];
                    dvd_next   = DIV_W'(sum_y_reg);
                    start_next = 1'b1;
                    state_next = ST_AVGY;
                end
            end
            ST_AVGY: begin
                if (div_stat.done) begin
                    avg_y_next = div_quot[RAW_W-1:0];
                    state_next = ST_MULX;
                end
            end
            ST_MULX, ST_MULY: begin
                neg_next = diff[RAW_W] ^ span[RAW_W];
                dvd_next = DIV_W'(prod);
                dvs_next = span_mag;
                if (span == '0) begin
                    // flat range maps to zero before mirroring
                    q_next     = '0;
                    state_next = (state_reg == ST_MULX) ? ST_FIXX : ST_FIXY;
                end else begin
                    start_next = 1'b1;
                    state_next = (state_reg == ST_MULX) ? ST_DIVX : ST_DIVY;
                end
            end
            ST_DIVX, ST_DIVY: begin
                if (div_stat.done) begin
                    q_next     = neg_reg ? -$signed(quot_ext) : $signed(quot_ext);
                    state_next = (state_reg == ST_DIVX) ? ST_FIXX : ST_FIXY;
                end
            end
            ST_FIXX: begin
                scr_x_next = m_clamp[SX_W-1:0];
                state_next = ST_MULY;
            end
            ST_FIXY: begin
                scr_y_next = m_clamp[SY_W-1:0];
                state_next = ST_OUT;
            end
            ST_OUT: begin
                // hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_touch_next = touch_reg;
                    m_ax_next    = touch_reg ? avg_x_reg : '0;
                    m_ay_next    = touch_reg ? avg_y_reg : '0;
                    m_sx_next    = touch_reg ? scr_x_reg : '0;
                    m_sy_next    = touch_reg ? scr_y_reg : '0;
                    sum_x_next   = '0;
                    sum_y_next   = '0;
                    vcnt_next    = '0;
                    scnt_next    = '0;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            swap_reg    <= RST_SWAP;
            inv_h_reg   <= RST_INV_H;
            inv_v_reg   <= RST_INV_V;
            min_h_reg   <= RST_MIN_H;
            max_h_reg   <= RST_MAX_H;
            min_v_reg   <= RST_MIN_V;
            max_v_reg   <= RST_MAX_V;
            sum_x_reg   <= '0;
            sum_y_reg   <= '0;
            vcnt_reg    <= '0;
            scnt_reg    <= '0;
            touch_reg   <= 1'b0;
            start_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            swap_reg    <= swap_next;
            inv_h_reg   <= inv_h_next;
            inv_v_reg   <= inv_v_next;
            min_h_reg   <= min_h_next;
            max_h_reg   <= max_h_next;
            min_v_reg   <= min_v_next;
            max_v_reg   <= max_v_next;
            sum_x_reg   <= sum_x_next;
            sum_y_reg   <= sum_y_next;
            vcnt_reg    <= vcnt_next;
            scnt_reg    <= scnt_next;
            touch_reg   <= touch_next;
            start_reg   <= start_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        avg_x_reg   <= avg_x_next;
        avg_y_reg   <= avg_y_next;
        dvd_reg     <= dvd_next;
        dvs_reg     <= dvs_next;
        neg_reg     <= neg_next;
        q_reg       <= q_next;
        scr_x_reg   <= scr_x_next;
        scr_y_reg   <= scr_y_next;
        m_touch_reg <= m_touch_next;
        m_ax_reg    <= m_ax_next;
        m_ay_reg    <= m_ay_next;
        m_sx_reg    <= m_sx_next;
        m_sy_reg    <= m_sy_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_touch_valid = m_touch_reg;
    assign m_average_x   = m_ax_reg;
    assign m_average_y   = m_ay_reg;
    assign m_screen_x    = m_sx_reg;
    assign m_screen_y    = m_sy_reg;

`ifndef NO_ASSERTIONS
    a_start_state: assert property (@(posedge aclk) disable iff (!aresetn)
        start_reg |-> (state_reg == ST_AVGX || state_reg == ST_AVGY ||
                       state_reg == ST_DIVX || state_reg == ST_DIVY))
        else $error("divider started outside a divide state");

    a_div_free: assert property (@(posedge aclk) disable iff (!aresetn)
        start_reg |-> !div_stat.busy)
        else $error("divider restarted while busy");

    a_no_touch_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_touch_valid) |-> (m_average_x == '0 && m_average_y == '0 &&
                                         m_screen_x == '0 && m_screen_y == '0))
        else $error("result without touch carries non-zero fields");

    a_idle_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> (scnt_reg <= LAST_CNT))
        else $error("group count overran while idle");

    a_group_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && scnt_reg == LAST_CNT) |=> (state_reg != ST_IDLE && !s_ready))
        else $error("group end did not start the sequencer");
`endif

endmodule

@@ rtl/tam_div.sv @@
// Restoring unsigned divider, one quotient bit per cycle, shared by the
// averaging and the mapping steps. Depends on tam_pkg.
`timescale 1ns / 1ps

module tam_div #(
    parameter int DIV_W = 24,
    parameter int DVS_W = 12
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [DIV_W-1:0]    dividend,
    input  logic [DVS_W-1:0]    divisor,
    output tam_pkg::div_stat_t  stat,
    output logic [DIV_W-1:0]    quotient
);
    import tam_pkg::*;

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W-1:0] acc_reg, acc_next;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVS_W:0]   rem_sh;
    logic [DVS_W:0]   trial;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        rem_next  = rem_reg;
        rem_sh    = {rem_reg, acc_reg[DIV_W-1]};
        trial     = rem_sh - {1'b0, divisor};
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIV_W);
            acc_next  = dividend;
            rem_next  = '0;
        end else if (busy_reg) begin
            // shift the next dividend bit in, keep the difference if it fits
            if (!trial[DVS_W]) begin
                rem_next = trial[DVS_W-1:0];
                acc_next = {acc_reg[DIV_W-2:0], 1'b1};
            end else begin
                rem_next = rem_sh[DVS_W-1:0];
                acc_next = {acc_reg[DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
        rem_reg <= rem_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = acc_reg;

endmodule
